// File: design/dertlv_pkg.sv
// ----------------------------------------------------------------------------
// dertlv_pkg
// Shared types and constants for the DER tag-length header parser: beat
// layouts of both stream sides and the result status codes.
// ----------------------------------------------------------------------------
package dertlv_pkg;

    localparam logic [7:0] LONG_FORM_BIT = 8'h80;
    localparam logic [7:0] LEN_MASK      = 8'h7f;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_TAG    = 3'd1,
        ST_SHORT  = 3'd2,
        ST_FORM   = 3'd3,
        ST_BOUNDS = 3'd4
    } status_t;

    typedef struct packed {
        logic [63:0] remain_size;
        logic [7:0]  expected_tag;
        logic        start_req;
        logic [7:0]  data_byte;
    } in_beat_t;

    typedef struct packed {
        logic [63:0] remain_after_element;
        logic [63:0] remain_after_header;
        logic [3:0]  header_length;
        logic [63:0] content_length;
        status_t     status;
    } result_t;

endpackage

// File: design/dertlv_core.sv
// ----------------------------------------------------------------------------
// dertlv_core
// Header state and per-beat decision logic: takes one registered beat per
// step, updates the parse state and flags a result when a header completes or fails.
// ----------------------------------------------------------------------------
module dertlv_core #(
    parameter int MAX_LENGTH_OCTETS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  dertlv_pkg::in_beat_t beat,
    output logic                res_valid,
    output dertlv_pkg::result_t res
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LEN  = 2'd1,
        PH_LONG = 2'd2
    } phase_t;

    localparam logic [6:0] LEN_MASK_7 = dertlv_pkg::LEN_MASK[6:0];

    phase_t      phase_reg, phase_next;
    logic [3:0]  octet_count_reg, octet_count_next;
    logic [3:0]  octets_left_reg, octets_left_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] remain_reg, remain_next;
    logic [63:0] after_hdr_reg, after_hdr_next;

    logic [64:0] start_diff;
    logic [64:0] long_diff;
    logic [64:0] elem_diff;
    logic [6:0]  n_octets;
    logic [3:0]  hdr_long;
    logic [3:0]  hdr_fin;
    logic [63:0] acc_shift;
    logic [63:0] len_fin;
    logic [3:0]  left_dec;
    logic        is_long;

    function automatic dertlv_pkg::result_t make_reject(
        input dertlv_pkg::status_t st,
        input logic [3:0]          hdr,
        input logic [63:0]         remain
    );
        dertlv_pkg::result_t r;
        r.status               = st;
        r.content_length       = 64'd0;
        r.header_length        = hdr;
        r.remain_after_header  = remain;
        r.remain_after_element = remain;
        return r;
    endfunction

    assign start_diff = {1'b0, beat.remain_size} - 65'd2;
    assign n_octets   = beat.data_byte[6:0] & LEN_MASK_7;
    assign hdr_long   = 4'd2 + n_octets[3:0];
    assign long_diff  = {1'b0, remain_reg} - {61'd0, hdr_long};
    assign acc_shift  = {acc_reg[55:0], beat.data_byte};
    assign left_dec   = (octets_left_reg != 4'd0) ? octets_left_reg - 4'd1 : 4'd0;
    assign is_long    = (phase_reg == PH_LONG);
    assign len_fin    = is_long ? acc_shift : {56'd0, beat.data_byte};
    assign hdr_fin    = is_long ? 4'd2 + octet_count_reg : 4'd2;
    assign elem_diff  = {1'b0, after_hdr_reg} - {1'b0, len_fin};

    always_comb
    begin
        phase_next       = phase_reg;
        octet_count_next = octet_count_reg;
        octets_left_next = octets_left_reg;
        acc_next         = acc_reg;
        remain_next      = remain_reg;
        after_hdr_next   = after_hdr_reg;
        res_valid        = 1'b0;
        res              = make_reject(dertlv_pkg::ST_OK, 4'd0, remain_reg);

        if (beat.start_req)
        begin
            remain_next      = beat.remain_size;
            after_hdr_next   = start_diff[63:0];
            octet_count_next = 4'd0;
            octets_left_next = 4'd0;
            acc_next         = 64'd0;
            if (start_diff[64])
            begin
                res_valid  = 1'b1;
                res        = make_reject(dertlv_pkg::ST_SHORT, 4'd1, beat.remain_size);
                phase_next = PH_IDLE;
            end
            else if (beat.data_byte != beat.expected_tag)
            begin
                res_valid  = 1'b1;
                res        = make_reject(dertlv_pkg::ST_TAG, 4'd1, beat.remain_size);
                phase_next = PH_IDLE;
            end
            else
            begin
                phase_next = PH_LEN;
            end
        end
        else
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    phase_next = PH_IDLE;
                    if ((beat.data_byte & dertlv_pkg::LONG_FORM_BIT) == 8'd0)
                    begin
                        res_valid = 1'b1;
                        if (elem_diff[64])
                        begin
                            res = make_reject(dertlv_pkg::ST_BOUNDS, hdr_fin, remain_reg);
                        end
                        else
                        begin
                            res.status               = dertlv_pkg::ST_OK;
                            res.content_length       = len_fin;
                            res.header_length        = hdr_fin;
                            res.remain_after_header  = after_hdr_reg;
                            res.remain_after_element = elem_diff[63:0];
                        end
                    end
                    else if (n_octets == 7'd0 || n_octets > 7'(MAX_LENGTH_OCTETS))
                    begin
                        res_valid = 1'b1;
                        res       = make_reject(dertlv_pkg::ST_FORM, 4'd2, remain_reg);
                    end
                    else if (long_diff[64])
                    begin
                        res_valid = 1'b1;
                        res       = make_reject(dertlv_pkg::ST_BOUNDS, 4'd2, remain_reg);
                    end
                    else
                    begin
                        octet_count_next = n_octets[3:0];
                        octets_left_next = n_octets[3:0];
                        acc_next         = 64'd0;
                        after_hdr_next   = long_diff[63:0];
                        phase_next       = PH_LONG;
                    end
                end
                PH_LONG:
                begin
                    acc_next         = acc_shift;
                    octets_left_next = left_dec;
                    if (left_dec == 4'd0)
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        if (acc_shift == 64'd1)
                        begin
                            res = make_reject(dertlv_pkg::ST_FORM, hdr_fin, remain_reg);
                        end
                        else if (elem_diff[64])
                        begin
                            res = make_reject(dertlv_pkg::ST_BOUNDS, hdr_fin, remain_reg);
                        end
                        else
                        begin
                            res.status               = dertlv_pkg::ST_OK;
                            res.content_length       = len_fin;
                            res.header_length        = hdr_fin;
                            res.remain_after_header  = after_hdr_reg;
                            res.remain_after_element = elem_diff[63:0];
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            octet_count_reg <= 4'd0;
            octets_left_reg <= 4'd0;
            acc_reg         <= 64'd0;
            remain_reg      <= 64'd0;
            after_hdr_reg   <= 64'd0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            octet_count_reg <= octet_count_next;
            octets_left_reg <= octets_left_next;
            acc_reg         <= acc_next;
            remain_reg      <= remain_next;
            after_hdr_reg   <= after_hdr_next;
        end
    end

endmodule

// File: design/der_tlv_header_parser.sv
// ----------------------------------------------------------------------------
// der_tlv_header_parser
// Checks one DER tag-length header per start beat and reports status, content
// length, header length and the remaining byte counts around the element.
// ----------------------------------------------------------------------------
// One beat is accepted every cycle while the result side keeps up. Each beat
// goes through an input register, the header logic and then a result
// register. The remaining count after the header is prepared a beat ahead, so
// each step needs only one 64-bit subtract and compare. Beats outside a
// header produce no result; a stalled result holds the input register.
module der_tlv_header_parser #(
    parameter int MAX_LENGTH_OCTETS = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // data_byte[7:0], expected_tag[15:8], remain_size[79:16]
    input  logic [79:0]  s_tdata,
    // start_req[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], content_length[66:3], header_length[70:67],
    // remain_after_header[134:71], remain_after_element[198:135], zero[199]
    output logic [199:0] m_tdata
);

    dertlv_pkg::in_beat_t in_reg;
    logic                 in_valid_reg, in_valid_next;
    dertlv_pkg::result_t  out_reg;
    logic                 out_valid_reg, out_valid_next;

    dertlv_pkg::result_t  res;
    logic                 res_valid;
    logic                 advance;
    logic                 step;
    logic                 s_fire;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    dertlv_core #(
        .MAX_LENGTH_OCTETS(MAX_LENGTH_OCTETS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .beat      (in_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = res_valid;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_reg.data_byte    <= s_tdata[7:0];
            in_reg.expected_tag <= s_tdata[15:8];
            in_reg.remain_size  <= s_tdata[79:16];
            in_reg.start_req    <= s_tuser;
        end
        if (step && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

    // stall only when a result is held back
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a held result");

    // accepted element: counts add up
    a_ok_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == dertlv_pkg::ST_OK) |->
        (out_reg.remain_after_element + out_reg.content_length
            == out_reg.remain_after_header))
        else $error("remaining counts inconsistent on accepted header");

    // rejected header: no length, counts unchanged
    a_reject_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != dertlv_pkg::ST_OK) |->
        (out_reg.content_length == 64'd0
            && out_reg.remain_after_header == out_reg.remain_after_element))
        else $error("rejected header carries length or changed counts");

    // header length stays within tag plus length octets
    a_hdr_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.header_length >= 4'd1
            && out_reg.header_length <= 4'd10))
        else $error("header length out of range");

endmodule
